### hw/rtl/drpg_pkg.sv
// Shared constants, register codes and the rainbow color table of the
// diagonal rainbow pixel generator. No dependencies.
`default_nettype none

package drpg_pkg;

    // Hue table size and field widths
    localparam int HUE_ENTRIES = 256;
    localparam int HUE_BITS    = $clog2(HUE_ENTRIES);
    localparam int COORD_W     = 11;
    localparam int FRAME_W     = 8;
    localparam int SIZE_W      = 12;
    localparam int SPEED_W     = 8;
    localparam int COLOR_W     = 16;
    localparam int CHAN_W      = 8;
    localparam int CHAN_MAX    = 255;

    // Divider geometry: numerator is (x + y) * HUE_ENTRIES, divisor is the span
    localparam int SUM_W       = COORD_W + 1;
    localparam int SPAN_W      = SIZE_W + 1;
    localparam int REM_W       = SPAN_W + 1;
    localparam int NUM_W       = SUM_W + HUE_BITS;
    localparam int DIV_STEPS   = NUM_W;

    // Pipeline stage map: input, one stage per quotient bit, index, color
    localparam int ST_IDX      = DIV_STEPS + 1;
    localparam int ST_OUT      = DIV_STEPS + 2;
    localparam int NSTAGE      = DIV_STEPS + 3;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_SCROLL_SPEED = 2'd2
    } t_cfg_index;

    localparam logic [SIZE_W-1:0]  WIDTH_RST  = 12'd480;
    localparam logic [SIZE_W-1:0]  HEIGHT_RST = 12'd480;
    localparam logic [SPEED_W-1:0] SPEED_RST  = 8'd3;

    // Full-saturation, full-value hue to RGB565; a constant table indexed by hue
    function automatic logic [COLOR_W-1:0] rainbow_color(input logic [HUE_BITS-1:0] idx);
        int six;
        int sector;
        int rem;
        int up;
        int down;
        int r;
        int g;
        int b;
        logic [CHAN_W-1:0] r8;
        logic [CHAN_W-1:0] g8;
        logic [CHAN_W-1:0] b8;
        six    = 6 * int'(idx);
        sector = six / HUE_ENTRIES;
        rem    = six % HUE_ENTRIES;
        up     = (CHAN_MAX * rem) / HUE_ENTRIES;
        down   = (CHAN_MAX * (HUE_ENTRIES - rem)) / HUE_ENTRIES;
        case (sector)
            0: begin
                r = CHAN_MAX; g = up;       b = 0;
            end
            1: begin
                r = down;     g = CHAN_MAX; b = 0;
            end
            2: begin
                r = 0;        g = CHAN_MAX; b = up;
            end
            3: begin
                r = 0;        g = down;     b = CHAN_MAX;
            end
            4: begin
                r = up;       g = 0;        b = CHAN_MAX;
            end
            default: begin
                r = CHAN_MAX; g = 0;        b = down;
            end
        endcase
        r8 = CHAN_W'(r);
        g8 = CHAN_W'(g);
        b8 = CHAN_W'(b);
        return {r8[7:3], g8[7:2], b8[7:3]};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/diagonal_rainbow_pixel_generator.sv
// Diagonal rainbow pixel generator: one module holding the whole pipeline.
// Depends on drpg_pkg for widths, register codes and the color table.
//
// Takes one pixel word (x, y, frame count) per clock and returns one RGB565
// word per clock while no stall holds the pipeline. The hue index is
// floor((x + y) * 256 / (width + height)) plus frame * speed, modulo 256;
// the division runs in a restoring divider of 20 registered stages, one
// quotient bit per stage, with the span register as a fixed divisor. A
// zero span gives a diagonal term of zero. Every stage holds its word on
// an output stall while empty stages ahead keep filling, so the input only
// stalls once all 23 stages are full. Configuration writes are always
// ready and take effect for words accepted from the next cycle on; change
// them only while no word is in flight.
`default_nettype none

module diagonal_rainbow_pixel_generator
    import drpg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // pixel input
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COORD_W-1:0]    i_pixel_x,
    input  wire logic [COORD_W-1:0]    i_pixel_y,
    input  wire logic [FRAME_W-1:0]    i_frame_count,
    // color output
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COLOR_W-1:0]         o_pixel_color,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;
    logic [SPEED_W-1:0] r_speed;
    logic [SPAN_W-1:0]  r_span;

    // Pipeline control
    logic [NSTAGE-1:0]  r_vld;
    logic [NSTAGE-1:0]  w_move;

    // Input stage
    logic [SUM_W-1:0]   r_sum;
    logic [HUE_BITS-1:0] r_shift;
    logic [FRAME_W+SPEED_W-1:0] w_prod;

    // Divider stages
    logic [SUM_W-1:0]    r_dsum [DIV_STEPS];
    logic [SPAN_W-1:0]   r_drem [DIV_STEPS];
    logic [HUE_BITS-1:0] r_dq   [DIV_STEPS];
    logic [HUE_BITS-1:0] r_dsh  [DIV_STEPS];
    logic [SUM_W-1:0]    w_src_sum [DIV_STEPS];
    logic [SPAN_W-1:0]   w_src_rem [DIV_STEPS];
    logic [HUE_BITS-1:0] w_src_q   [DIV_STEPS];
    logic [HUE_BITS-1:0] w_src_sh  [DIV_STEPS];
    logic [SPAN_W-1:0]   n_drem [DIV_STEPS];
    logic [HUE_BITS-1:0] n_dq   [DIV_STEPS];

    // Index and color stages
    logic [HUE_BITS-1:0] r_idx;
    logic [HUE_BITS-1:0] n_idx;
    logic [COLOR_W-1:0]  r_color;

    // Accept every configuration word; hold the span as a register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_speed  <= SPEED_RST;
            r_span   <= SPAN_W'(WIDTH_RST) + SPAN_W'(HEIGHT_RST);
        end else begin
            r_span <= SPAN_W'(r_width) + SPAN_W'(r_height);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                    CFG_SCROLL_SPEED: r_speed  <= i_cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // A stage may advance unless it and every stage ahead are full and stalled
    always_comb begin
        for (int k = 0; k < NSTAGE; k++) begin
            w_move[k] = !(i_stall &&
                (&(r_vld | ((NSTAGE'(1) << k) - NSTAGE'(1)))));
        end
    end

    assign o_stall       = !w_move[0];
    assign o_valid       = r_vld[ST_OUT];
    assign o_pixel_color = r_color;

    // Shift valid bits along with their words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_move[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_move[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Input stage: diagonal sum and scroll shift
    assign w_prod = i_frame_count * r_speed;

    always_ff @(posedge i_clk) begin
        if (w_move[0]) begin
            r_sum   <= SUM_W'(i_pixel_x) + SUM_W'(i_pixel_y);
            r_shift <= w_prod[HUE_BITS-1:0];
        end
    end

    // Route each divider stage's source word
    always_comb begin
        w_src_sum[0] = r_sum;
        w_src_rem[0] = '0;
        w_src_q[0]   = '0;
        w_src_sh[0]  = r_shift;
        for (int d = 1; d < DIV_STEPS; d++) begin
            w_src_sum[d] = r_dsum[d-1];
            w_src_rem[d] = r_drem[d-1];
            w_src_q[d]   = r_dq[d-1];
            w_src_sh[d]  = r_dsh[d-1];
        end
    end

    // One restoring step per stage: bring down a numerator bit, subtract if it fits
    always_comb begin
        logic [NUM_W-1:0] num;
        logic [REM_W-1:0] trial;
        logic             fits;
        for (int d = 0; d < DIV_STEPS; d++) begin
            num     = {w_src_sum[d], {HUE_BITS{1'b0}}};
            trial   = {w_src_rem[d], num[NUM_W-1-d]};
            fits    = trial >= {1'b0, r_span};
            n_drem[d] = fits ? SPAN_W'(trial - {1'b0, r_span}) : trial[SPAN_W-1:0];
            n_dq[d]   = {w_src_q[d][HUE_BITS-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < DIV_STEPS; d++) begin
            if (w_move[d+1]) begin
                r_dsum[d] <= w_src_sum[d];
                r_drem[d] <= n_drem[d];
                r_dq[d]   <= n_dq[d];
                r_dsh[d]  <= w_src_sh[d];
            end
        end
    end

    // Index stage: drop the diagonal term for a zero span, add the shift
    assign n_idx = ((r_span == '0) ? '0 : r_dq[DIV_STEPS-1]) + r_dsh[DIV_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (w_move[ST_IDX]) begin
            r_idx <= n_idx;
        end
        if (w_move[ST_OUT]) begin
            r_color <= rainbow_color(r_idx);
        end
    end

    // Accepted word always lands in the input stage
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word missing from input stage");

    // Delivered word with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_vld[ST_IDX]) |=> !o_valid)
        else $error("delivered word repeated at output");

    // Final divider remainder stays below a nonzero span
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_IDX-1] && (r_span != '0)) |-> (r_drem[DIV_STEPS-1] < r_span))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire
